### rtl/mgs_pkg.sv
package mgs_pkg;

  localparam int MAX_DIM   = 4;
  localparam int FRAC_BITS = 40;
  localparam int FX_W      = 64;

  localparam int SYS_DIM   = MAX_DIM + 1;
  localparam int SYS_COLS  = MAX_DIM + 2;
  localparam int DIM_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int NR_W      = $clog2(MAX_DIM + 1);
  localparam int SYS_W     = $clog2(SYS_COLS);
  localparam int SOL_W     = $clog2(SYS_DIM);
  localparam int W_DEPTH   = SYS_DIM * SYS_COLS;
  localparam int WADDR_W   = $clog2(W_DEPTH);
  localparam int P_DEPTH   = MAX_DIM * MAX_DIM;
  localparam int PADDR_W   = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
  localparam int OI_W      = $clog2(2 * MAX_DIM + 1);
  localparam int NUM_W     = FX_W + FRAC_BITS;

  typedef logic signed [FX_W-1:0] fx_t;
  typedef logic [MAX_DIM-1:0][DIM_W-1:0] idx_list_t;

  localparam fx_t FX_MAX     = {1'b0, {(FX_W-1){1'b1}}};
  localparam fx_t FX_MIN     = {1'b1, {(FX_W-1){1'b0}}};
  localparam fx_t ONE_FX     = 64'sd1 <<< FRAC_BITS;
  localparam fx_t NEG_ONE_FX = -ONE_FX;
  localparam logic [FX_W-1:0] PIVOT_MIN =
      ((64'd1 << FRAC_BITS) + 64'd50000000000) / 64'd100000000000;
  localparam fx_t SLACK =
      fx_t'(((64'd1 << (FRAC_BITS + 1)) + 64'd50000000) / 64'd100000000);
  localparam fx_t NEG_SLACK  = -SLACK;
  localparam logic [FX_W-1:0] VALUE_TOL =
      ((64'd1 << FRAC_BITS) + 64'd500000) / 64'd1000000;

  typedef enum logic [1:0] {
    KIND_VALUE = 2'd0,
    KIND_ROW   = 2'd1,
    KIND_COL   = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [5:0] {
    S_IDLE, S_RM, S_RM_ADV, S_CM, S_CM_ADV, S_BUILD_RD, S_BUILD_WR,
    S_PIV_INIT, S_PIV_RD, S_PIV_CMP, S_PIV_CHK,
    S_SW_RDP, S_SW_RDC, S_SW_WRC, S_SW_WRP,
    S_Z_RD, S_Z_CAP, S_N_RD, S_N_DIV, S_N_WAIT,
    S_E_ROW, S_E_F, S_E_RDC, S_E_MUL, S_E_WAIT, S_E_NEXT,
    S_COPY, S_COPY_CAP, S_CHK_VAL, S_BR_RD, S_BR_MUL, S_BR_WAIT,
    S_OUT, S_FAIL
  } state_t;

  function automatic logic [FX_W-1:0] mag(fx_t a);
    logic [FX_W-1:0] m;
    m = a;
    if (a[FX_W-1]) m = ~m + 1'b1;
    return m;
  endfunction

  function automatic fx_t sat_add(fx_t a, fx_t b);
    fx_t s;
    s = a + b;
    if (a[FX_W-1] == b[FX_W-1] && s[FX_W-1] != a[FX_W-1]) return a[FX_W-1] ? FX_MIN : FX_MAX;
    return s;
  endfunction

  function automatic fx_t sat_sub(fx_t a, fx_t b);
    fx_t d;
    d = a - b;
    if (a[FX_W-1] != b[FX_W-1] && d[FX_W-1] != a[FX_W-1]) return a[FX_W-1] ? FX_MIN : FX_MAX;
    return d;
  endfunction

  function automatic logic [SYS_W-1:0] popcount(logic [MAX_DIM-1:0] v);
    logic [SYS_W-1:0] n;
    n = '0;
    for (int i = 0; i < MAX_DIM; i++) n = n + SYS_W'(v[i]);
    return n;
  endfunction

  function automatic idx_list_t members(logic [MAX_DIM-1:0] mask);
    idx_list_t list;
    logic [DIM_W:0] cnt;
    list = '0;
    cnt = '0;
    for (int i = 0; i < MAX_DIM; i++) begin
      if (mask[i]) begin
        list[cnt[DIM_W-1:0]] = DIM_W'(i);
        cnt = cnt + 1'b1;
      end
    end
    return list;
  endfunction

  function automatic logic [WADDR_W-1:0] waddr(logic [SYS_W-1:0] r, logic [SYS_W-1:0] c);
    return WADDR_W'(int'(r) * SYS_COLS + int'(c));
  endfunction

  function automatic logic [PADDR_W-1:0] paddr(logic [DIM_W-1:0] i, logic [DIM_W-1:0] j);
    return PADDR_W'(int'(i) * MAX_DIM + int'(j));
  endfunction

  function automatic logic [NR_W-1:0] sat_dim(logic [2:0] v);
    if (v == 3'd0) return NR_W'(1);
    if (int'(v) > MAX_DIM) return NR_W'(MAX_DIM);
    return NR_W'(v);
  endfunction

endpackage

### rtl/mgs_ram.sv
module mgs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

### rtl/mgs_mul.sv
module mgs_mul import mgs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  fx_t  a,
  input  fx_t  b,
  output logic done,
  output fx_t  prod
);

  logic [FX_W-1:0]   ma, mb;
  logic              neg;
  logic [2*FX_W-1:0] acc;
  logic [2:0]        step;
  logic              active;
  logic [31:0]       pa, pb;
  logic [63:0]       part;
  logic [2*FX_W-1:0] shifted, rounded;

  // Four 32x32 partial products, one per cycle, then a rounding step.
  always_comb begin
    pa = step[0] ? ma[63:32] : ma[31:0];
    pb = step[1] ? mb[63:32] : mb[31:0];
    part = pa * pb;
    case (step)
      3'd0:    shifted = {64'd0, part};
      3'd1:    shifted = {32'd0, part, 32'd0};
      3'd2:    shifted = {32'd0, part, 32'd0};
      3'd3:    shifted = {part, 64'd0};
      default: shifted = '0;
    endcase
    rounded = (acc + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= !start && active && step == 3'd4;
      if (start) begin
        ma     <= mag(a);
        mb     <= mag(b);
        neg    <= a[FX_W-1] != b[FX_W-1];
        acc    <= '0;
        step   <= '0;
        active <= 1'b1;
      end else if (active) begin
        if (step == 3'd4) begin
          active <= 1'b0;
          if (rounded[2*FX_W-1:FX_W-1] != '0) prod <= neg ? FX_MIN : FX_MAX;
          else if (neg) prod <= -fx_t'(rounded[FX_W-1:0]);
          else prod <= fx_t'(rounded[FX_W-1:0]);
        end else begin
          acc  <= acc + shifted;
          step <= step + 1'b1;
        end
      end
    end
  end

endmodule

### rtl/mgs_div.sv
module mgs_div import mgs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  fx_t  a,
  input  fx_t  b,
  output logic done,
  output fx_t  quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [FX_W-1:0]  mb, rem;
  logic [NUM_W-1:0] num, q;
  logic             neg, active, zero_div, a_neg, a_zero;
  logic [CNT_W-1:0] cnt;
  logic [FX_W:0]    rem_sh;
  logic [NUM_W:0]   q_rnd;

  always_comb begin
    rem_sh = {rem, num[NUM_W-1]};
    q_rnd  = {1'b0, q} + (({rem, 1'b0} >= {1'b0, mb}) ? 1'b1 : 1'b0);
  end

  // Restoring division, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= !start && active && cnt == '0;
      if (start) begin
        mb       <= mag(b);
        num      <= {mag(a), {FRAC_BITS{1'b0}}};
        rem      <= '0;
        q        <= '0;
        neg      <= a[FX_W-1] != b[FX_W-1];
        zero_div <= b == '0;
        a_neg    <= a[FX_W-1];
        a_zero   <= a == '0;
        cnt      <= CNT_W'(NUM_W);
        active   <= 1'b1;
      end else if (active) begin
        if (cnt == '0) begin
          active <= 1'b0;
          if (zero_div) quot <= a_zero ? '0 : (a_neg ? FX_MIN : FX_MAX);
          else if (q_rnd[NUM_W:FX_W-1] != '0) quot <= neg ? FX_MIN : FX_MAX;
          else if (neg) quot <= -fx_t'(q_rnd[FX_W-1:0]);
          else quot <= fx_t'(q_rnd[FX_W-1:0]);
        end else begin
          num <= num << 1;
          cnt <= cnt - 1'b1;
          if (rem_sh >= {1'b0, mb}) begin
            rem <= FX_W'(rem_sh - {1'b0, mb});
            q   <= {q[NUM_W-2:0], 1'b1};
          end else begin
            rem <= rem_sh[FX_W-1:0];
            q   <= {q[NUM_W-2:0], 1'b0};
          end
        end
      end
    end
  end

endmodule

### rtl/matrix_game_solver.sv
// Zero-sum matrix game solver.
// Requests load the payoff matrix one entry per request: a request is taken
// at a rising edge with start high and busy low, and stores entry at
// (row_index, col_index). A request with last_entry set also starts a solve
// of the num_rows x num_cols game; busy stays high until the final result is
// on the ports, and falls in that cycle.
// A solve walks support pairs of rising size, builds two small linear systems
// in the work memory and eliminates them there. Its length depends on the
// game. The bit-serial divider and the multiplier, fed through the single
// read port of the work memory (the multiplier from the payoff memory in
// the best-response check), set its length.
// Results appear one per cycle, each for one cycle with result_strobe high:
// the value, then row and column probabilities, last_result on the final
// one, or a single no-equilibrium result. The receiver cannot stall them.
// Reset aborts any solve and clears the strategies and dimensions; payoff
// entries are undefined until written.
module matrix_game_solver import mgs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  num_rows,
  input  logic [2:0]  num_cols,
  input  logic [1:0]  row_index,
  input  logic [1:0]  col_index,
  input  fx_t         entry,
  input  logic        last_entry,
  output logic        result_strobe,
  output logic [1:0]  result_kind,
  output logic [1:0]  position,
  output fx_t         amount,
  output logic        last_result
);

  state_t state, state_next;

  logic [NR_W-1:0]    nr, nc, kmax;
  logic [SYS_W-1:0]   k, n, last_r, r, j, c, piv;
  logic [MAX_DIM-1:0] rm, cm, rm_last, cm_last;
  idx_list_t          rs, cs;
  logic               side, phase;
  logic [FX_W-1:0]    best;
  fx_t                zv, fv, tmp, acc, lo_thr, hi_thr;
  fx_t                rsol [SYS_DIM];
  fx_t                csol [SYS_DIM];
  fx_t                rstrat [MAX_DIM];
  fx_t                cstrat [MAX_DIM];
  fx_t                rstrat_next [MAX_DIM];
  fx_t                cstrat_next [MAX_DIM];
  logic [DIM_W-1:0]   bi, bj;
  logic [OI_W-1:0]    oi, ridx, cidx;

  logic               accept;
  logic               work_we, work_re, pay_re, pay_we;
  logic [WADDR_W-1:0] work_waddr, work_raddr;
  fx_t                work_wdata, work_rdata, pay_rdata;
  logic [PADDR_W-1:0] pay_raddr, pay_waddr;
  logic               mul_start, mul_done, div_start, div_done;
  fx_t                mul_a, mul_b, mul_prod, div_quot;

  fx_t                vp, vq, acc_sum, bconst;
  logic               val_ok, inner_end, outer_end, br_bad, in_block, out_last;

  assign accept    = start && !busy;
  assign busy      = state != S_IDLE;
  assign n         = k + 1'b1;
  assign last_r    = k;
  assign kmax      = (nr < nc) ? nr : nc;
  assign rm_last   = MAX_DIM'((1 << nr) - 1);
  assign cm_last   = MAX_DIM'((1 << nc) - 1);
  assign vp        = rsol[k[SOL_W-1:0]];
  assign vq        = csol[k[SOL_W-1:0]];
  assign pay_we    = accept && int'(row_index) < MAX_DIM && int'(col_index) < MAX_DIM;
  assign pay_waddr = paddr(DIM_W'(row_index), DIM_W'(col_index));
  assign acc_sum   = sat_add(acc, mul_prod);
  assign inner_end = phase ? (NR_W'(bj) + 1'b1 == nc) : (NR_W'(bi) + 1'b1 == nr);
  assign outer_end = phase ? (NR_W'(bi) + 1'b1 == nr) : (NR_W'(bj) + 1'b1 == nc);
  assign br_bad    = phase ? (acc_sum > hi_thr) : (acc_sum < lo_thr);
  assign in_block  = (r < k) && (j < k);
  assign ridx      = oi - 1'b1;
  assign cidx      = oi - 1'b1 - OI_W'(nr);
  assign out_last  = oi == OI_W'(nr) + OI_W'(nc);

  always_comb begin
    if (r < k) bconst = (j == k) ? NEG_ONE_FX : '0;
    else bconst = (j < k || j == k + 1'b1) ? ONE_FX : '0;
  end

  always_comb begin
    val_ok = mag(sat_sub(vp, vq)) <= VALUE_TOL;
    for (int i = 0; i < MAX_DIM; i++) begin
      if (i < int'(k) && (rsol[i] < NEG_SLACK || csol[i] < NEG_SLACK)) val_ok = 1'b0;
    end
  end

  // Support members overwrite the cleared entries with their clamped weights.
  always_comb begin
    for (int i = 0; i < MAX_DIM; i++) begin
      rstrat_next[i] = '0;
      cstrat_next[i] = '0;
    end
    for (int i = 0; i < MAX_DIM; i++) begin
      if (i < int'(k)) begin
        rstrat_next[rs[i]] = (rsol[i] > 0) ? rsol[i] : '0;
        cstrat_next[cs[i]] = (csol[i] > 0) ? csol[i] : '0;
      end
    end
  end

  mgs_ram #(.WIDTH(FX_W), .DEPTH(P_DEPTH)) u_payoff (
    .clk(clk), .we(pay_we), .waddr(pay_waddr), .wdata(entry),
    .re(pay_re), .raddr(pay_raddr), .rdata(pay_rdata)
  );

  mgs_ram #(.WIDTH(FX_W), .DEPTH(W_DEPTH)) u_work (
    .clk(clk), .we(work_we), .waddr(work_waddr), .wdata(work_wdata),
    .re(work_re), .raddr(work_raddr), .rdata(work_rdata)
  );

  mgs_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(mul_prod)
  );

  mgs_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .a(work_rdata), .b(zv),
    .done(div_done), .quot(div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    work_we    = 1'b0;
    work_re    = 1'b0;
    work_waddr = waddr(r, j);
    work_raddr = waddr(r, j);
    work_wdata = '0;
    pay_re     = 1'b0;
    pay_raddr  = side ? paddr(rs[r[DIM_W-1:0]], cs[j[DIM_W-1:0]])
                      : paddr(rs[j[DIM_W-1:0]], cs[r[DIM_W-1:0]]);
    mul_start  = 1'b0;
    mul_a      = fv;
    mul_b      = work_rdata;
    div_start  = 1'b0;
    case (state)
      S_IDLE: if (accept && last_entry) state_next = S_RM;
      S_RM: state_next = (popcount(rm) == k) ? S_CM : S_RM_ADV;
      S_RM_ADV: begin
        if (rm == rm_last && k == SYS_W'(kmax)) state_next = S_FAIL;
        else state_next = S_RM;
      end
      S_CM: state_next = (popcount(cm) == k) ? S_BUILD_RD : S_CM_ADV;
      S_CM_ADV: state_next = (cm == cm_last) ? S_RM_ADV : S_CM;
      S_BUILD_RD: begin
        pay_re = 1'b1;
        state_next = S_BUILD_WR;
      end
      S_BUILD_WR: begin
        work_we = 1'b1;
        work_wdata = in_block ? pay_rdata : bconst;
        if (j == k + 1'b1 && r == k) state_next = S_PIV_INIT;
        else state_next = S_BUILD_RD;
      end
      S_PIV_INIT: state_next = S_PIV_RD;
      S_PIV_RD: begin
        work_re = 1'b1;
        work_raddr = waddr(r, c);
        state_next = S_PIV_CMP;
      end
      S_PIV_CMP: state_next = (r == last_r) ? S_PIV_CHK : S_PIV_RD;
      S_PIV_CHK: begin
        if (best < PIVOT_MIN) state_next = S_CM_ADV;
        else if (piv != c) state_next = S_SW_RDP;
        else state_next = S_Z_RD;
      end
      S_SW_RDP: begin
        work_re = 1'b1;
        work_raddr = waddr(piv, j);
        state_next = S_SW_RDC;
      end
      S_SW_RDC: begin
        work_re = 1'b1;
        work_raddr = waddr(c, j);
        state_next = S_SW_WRC;
      end
      S_SW_WRC: begin
        work_we = 1'b1;
        work_waddr = waddr(c, j);
        work_wdata = tmp;
        state_next = S_SW_WRP;
      end
      S_SW_WRP: begin
        // The read data still holds the old entry of row c.
        work_we = 1'b1;
        work_waddr = waddr(piv, j);
        work_wdata = work_rdata;
        state_next = (j == n) ? S_Z_RD : S_SW_RDP;
      end
      S_Z_RD: begin
        work_re = 1'b1;
        work_raddr = waddr(c, c);
        state_next = S_Z_CAP;
      end
      S_Z_CAP: state_next = S_N_RD;
      S_N_RD: begin
        work_re = 1'b1;
        work_raddr = waddr(c, j);
        state_next = S_N_DIV;
      end
      S_N_DIV: begin
        div_start = 1'b1;
        state_next = S_N_WAIT;
      end
      S_N_WAIT: begin
        if (div_done) begin
          work_we = 1'b1;
          work_waddr = waddr(c, j);
          work_wdata = div_quot;
          state_next = (j == n) ? S_E_ROW : S_N_RD;
        end
      end
      S_E_ROW: begin
        if (r == c) state_next = S_E_NEXT;
        else begin
          work_re = 1'b1;
          work_raddr = waddr(r, c);
          state_next = S_E_F;
        end
      end
      S_E_F: state_next = S_E_RDC;
      S_E_RDC: begin
        work_re = 1'b1;
        work_raddr = waddr(c, j);
        state_next = S_E_MUL;
      end
      S_E_MUL: begin
        // The multiplier takes the pivot-row entry at this edge while the
        // target entry is fetched.
        mul_start = 1'b1;
        work_re = 1'b1;
        state_next = S_E_WAIT;
      end
      S_E_WAIT: begin
        if (mul_done) begin
          work_we = 1'b1;
          work_wdata = sat_sub(work_rdata, mul_prod);
          state_next = (j == n) ? S_E_NEXT : S_E_RDC;
        end
      end
      S_E_NEXT: begin
        if (r != last_r) state_next = S_E_ROW;
        else state_next = (c == last_r) ? S_COPY : S_PIV_INIT;
      end
      S_COPY: begin
        work_re = 1'b1;
        work_raddr = waddr(r, n);
        state_next = S_COPY_CAP;
      end
      S_COPY_CAP: begin
        if (r != last_r) state_next = S_COPY;
        else state_next = side ? S_CHK_VAL : S_BUILD_RD;
      end
      S_CHK_VAL: state_next = val_ok ? S_BR_RD : S_CM_ADV;
      S_BR_RD: begin
        pay_re = 1'b1;
        pay_raddr = paddr(bi, bj);
        state_next = S_BR_MUL;
      end
      S_BR_MUL: begin
        mul_start = 1'b1;
        mul_a = pay_rdata;
        mul_b = phase ? cstrat[bj] : rstrat[bi];
        state_next = S_BR_WAIT;
      end
      S_BR_WAIT: begin
        if (mul_done) begin
          if (inner_end && br_bad) state_next = S_CM_ADV;
          else if (inner_end && outer_end && phase) state_next = S_OUT;
          else state_next = S_BR_RD;
        end
      end
      S_OUT: if (out_last) state_next = S_IDLE;
      S_FAIL: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nr <= '0;
      nc <= '0;
      result_strobe <= 1'b0;
      for (int i = 0; i < MAX_DIM; i++) begin
        rstrat[i] <= '0;
        cstrat[i] <= '0;
      end
    end else begin
      result_strobe <= state == S_OUT || state == S_FAIL;
      case (state)
        S_IDLE: begin
          if (accept) begin
            nr <= sat_dim(num_rows);
            nc <= sat_dim(num_cols);
            k  <= SYS_W'(1);
            rm <= '0;
          end
        end
        S_RM: begin
          rs <= members(rm);
          cm <= '0;
        end
        S_RM_ADV: begin
          if (rm == rm_last) begin
            k  <= k + 1'b1;
            rm <= '0;
          end else rm <= rm + 1'b1;
        end
        S_CM: begin
          cs   <= members(cm);
          side <= 1'b0;
          r    <= '0;
          j    <= '0;
        end
        S_CM_ADV: if (cm != cm_last) cm <= cm + 1'b1;
        S_BUILD_WR: begin
          if (j == k + 1'b1) begin
            j <= '0;
            if (r == k) c <= '0;
            else r <= r + 1'b1;
          end else j <= j + 1'b1;
        end
        S_PIV_INIT: begin
          r    <= c;
          piv  <= c;
          best <= '0;
        end
        S_PIV_CMP: begin
          if (mag(work_rdata) > best) begin
            best <= mag(work_rdata);
            piv  <= r;
          end
          if (r != last_r) r <= r + 1'b1;
        end
        S_PIV_CHK: j <= '0;
        S_SW_RDC: tmp <= work_rdata;
        S_SW_WRP: if (j != n) j <= j + 1'b1;
        S_Z_CAP: begin
          zv <= work_rdata;
          j  <= c;
        end
        S_N_WAIT: begin
          if (div_done) begin
            if (j == n) r <= '0;
            else j <= j + 1'b1;
          end
        end
        S_E_F: begin
          fv <= work_rdata;
          j  <= c;
        end
        S_E_WAIT: if (mul_done && j != n) j <= j + 1'b1;
        S_E_NEXT: begin
          if (r == last_r) begin
            r <= '0;
            if (c != last_r) c <= c + 1'b1;
          end else r <= r + 1'b1;
        end
        S_COPY_CAP: begin
          if (side) csol[r[SOL_W-1:0]] <= work_rdata;
          else rsol[r[SOL_W-1:0]] <= work_rdata;
          if (r == last_r) begin
            r    <= '0;
            j    <= '0;
            side <= 1'b1;
          end else r <= r + 1'b1;
        end
        S_CHK_VAL: begin
          for (int i = 0; i < MAX_DIM; i++) begin
            rstrat[i] <= rstrat_next[i];
            cstrat[i] <= cstrat_next[i];
          end
          lo_thr <= sat_sub(vp, SLACK);
          hi_thr <= sat_add(vp, SLACK);
          bi     <= '0;
          bj     <= '0;
          phase  <= 1'b0;
          acc    <= '0;
        end
        S_BR_WAIT: begin
          if (mul_done) begin
            if (!inner_end) begin
              acc <= acc_sum;
              if (phase) bj <= bj + 1'b1;
              else bi <= bi + 1'b1;
            end else begin
              acc <= '0;
              if (!outer_end) begin
                if (phase) begin
                  bj <= '0;
                  bi <= bi + 1'b1;
                end else begin
                  bi <= '0;
                  bj <= bj + 1'b1;
                end
              end else begin
                phase <= 1'b1;
                bi    <= '0;
                bj    <= '0;
                oi    <= '0;
              end
            end
          end
        end
        S_OUT: begin
          oi          <= oi + 1'b1;
          last_result <= out_last;
          if (oi == '0) begin
            result_kind <= KIND_VALUE;
            position    <= 2'd0;
            amount      <= vp;
          end else if (oi <= OI_W'(nr)) begin
            result_kind <= KIND_ROW;
            position    <= 2'(ridx);
            amount      <= rstrat[ridx[DIM_W-1:0]];
          end else begin
            result_kind <= KIND_COL;
            position    <= 2'(cidx);
            amount      <= cstrat[cidx[DIM_W-1:0]];
          end
        end
        S_FAIL: begin
          result_kind <= KIND_NONE;
          position    <= 2'd0;
          amount      <= '0;
          last_result <= 1'b1;
          for (int i = 0; i < MAX_DIM; i++) begin
            rstrat[i] <= '0;
            cstrat[i] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  a_no_work_collision: assert property (@(posedge clk) disable iff (rst)
    !(work_we && work_re && work_waddr == work_raddr))
    else $error("work memory read and write to the same entry");

  a_mul_done_waited: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == S_E_WAIT || state == S_BR_WAIT))
    else $error("multiplier finished outside a wait state");

  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_N_WAIT)
    else $error("divider finished outside its wait state");

  a_solve_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && last_entry) |=> busy)
    else $error("solve request did not raise busy");

  a_last_ends_burst: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && last_result) |=> !result_strobe)
    else $error("result after the final result of a solve");

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

module tb import mgs_pkg::*;;

  typedef struct {
    kind_t       kind;
    logic [1:0]  pos;
    fx_t         amt;
    logic        last;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  num_rows = '0;
  logic [2:0]  num_cols = '0;
  logic [1:0]  row_index = '0;
  logic [1:0]  col_index = '0;
  fx_t         entry = '0;
  logic        last_entry = 1'b0;
  logic        result_strobe;
  logic [1:0]  result_kind;
  logic [1:0]  position;
  fx_t         amount;
  logic        last_result;

  outcome_t outcome_q[$];
  int       error_count = 0;
  int       item_count = 0;
  int       burst_left = 0;

  // Shadow of the payoff store and the scratch used by the equilibrium search.
  fx_t shadow_pay[4][4];
  fx_t gm[5][6];
  fx_t xsol[5];
  fx_t rsol[5];
  fx_t csol[5];
  fx_t rstrat[4];
  fx_t cstrat[4];
  int  rl[4];
  int  cl[4];

  localparam fx_t I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam fx_t I64_MIN = 64'sh8000_0000_0000_0000;
  localparam logic [63:0] PIV_LIM = ((64'd1 << 40) + 64'd50000000000) / 64'd100000000000;
  localparam fx_t MARGIN = fx_t'(((64'd1 << 41) + 64'd50000000) / 64'd100000000);
  localparam logic [63:0] AGREE_TOL = ((64'd1 << 40) + 64'd500000) / 64'd1000000;

  matrix_game_solver dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .num_rows(num_rows), .num_cols(num_cols), .row_index(row_index),
    .col_index(col_index), .entry(entry), .last_entry(last_entry),
    .result_strobe(result_strobe), .result_kind(result_kind), .position(position),
    .amount(amount), .last_result(last_result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void queue_outcome(outcome_t o);
    outcome_q = {outcome_q, o};
  endfunction

  function automatic logic [127:0] absval(fx_t a);
    logic [63:0] m;
    m = a;
    if (a < 0) m = ~m + 64'd1;
    return {64'd0, m};
  endfunction

  function automatic fx_t clip(bit neg, logic [127:0] m);
    if (neg) begin
      if (m >= 128'h8000_0000_0000_0000) return I64_MIN;
      return -fx_t'(m[63:0]);
    end
    if (m > 128'h7FFF_FFFF_FFFF_FFFF) return I64_MAX;
    return fx_t'(m[63:0]);
  endfunction

  function automatic fx_t add_sat(fx_t a, fx_t b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(I64_MAX)) return I64_MAX;
    if (s < 65'(I64_MIN)) return I64_MIN;
    return fx_t'(s);
  endfunction

  function automatic fx_t sub_sat(fx_t a, fx_t b);
    logic signed [64:0] d;
    d = 65'(a) - 65'(b);
    if (d > 65'(I64_MAX)) return I64_MAX;
    if (d < 65'(I64_MIN)) return I64_MIN;
    return fx_t'(d);
  endfunction

  // Products and quotients round to nearest, ties away from zero.
  function automatic fx_t times(fx_t a, fx_t b);
    logic [127:0] p;
    p = absval(a) * absval(b);
    p = (p + (128'd1 << 39)) >> 40;
    return clip((a < 0) != (b < 0), p);
  endfunction

  function automatic fx_t quotient(fx_t a, fx_t b);
    logic [127:0] num, den, q, r;
    den = absval(b);
    if (den == 0) return (a < 0) ? I64_MIN : ((a > 0) ? I64_MAX : fx_t'(0));
    num = absval(a) << 40;
    q = num / den;
    r = num % den;
    if (r >= den - r) q = q + 1;
    return clip((a < 0) != (b < 0), q);
  endfunction

  function automatic bit eliminate(int n);
    int piv;
    fx_t z, f, t;
    for (int c = 0; c < n; c++) begin
      piv = c;
      for (int r = c + 1; r < n; r++)
        if (absval(gm[r][c]) > absval(gm[piv][c])) piv = r;
      if (absval(gm[piv][c]) < {64'd0, PIV_LIM}) return 1'b0;
      if (piv != c)
        for (int j = 0; j <= n; j++) begin
          t = gm[piv][j];
          gm[piv][j] = gm[c][j];
          gm[c][j] = t;
        end
      z = gm[c][c];
      for (int j = c; j <= n; j++) gm[c][j] = quotient(gm[c][j], z);
      for (int r = 0; r < n; r++) begin
        if (r == c) continue;
        f = gm[r][c];
        for (int j = c; j <= n; j++) gm[r][j] = sub_sat(gm[r][j], times(f, gm[c][j]));
      end
    end
    for (int r = 0; r < n; r++) xsol[r] = gm[r][n];
    return 1'b1;
  endfunction

  // Indifference system for one player over the supports in rl and cl.
  function automatic void setup_system(int k, bit for_rows);
    for (int a = 0; a < 5; a++)
      for (int b = 0; b < 6; b++) gm[a][b] = '0;
    for (int a = 0; a < k; a++) begin
      for (int b = 0; b < k; b++)
        gm[a][b] = for_rows ? shadow_pay[rl[b]][cl[a]] : shadow_pay[rl[a]][cl[b]];
      gm[a][k] = -(64'sd1 <<< 40);
      gm[k][a] = 64'sd1 <<< 40;
    end
    gm[k][k + 1] = 64'sd1 <<< 40;
  endfunction

  function automatic bit support_pair_holds(int nr, int nc, int k);
    fx_t z;
    bit ok;
    ok = 1'b1;
    setup_system(k, 1'b1);
    if (!eliminate(k + 1)) return 1'b0;
    rsol = xsol;
    setup_system(k, 1'b0);
    if (!eliminate(k + 1)) return 1'b0;
    csol = xsol;
    if (absval(sub_sat(rsol[k], csol[k])) > {64'd0, AGREE_TOL}) return 1'b0;
    for (int i = 0; i < k; i++)
      if (rsol[i] < -MARGIN || csol[i] < -MARGIN) ok = 1'b0;
    for (int i = 0; i < 4; i++) begin
      rstrat[i] = '0;
      cstrat[i] = '0;
    end
    for (int i = 0; i < k; i++) begin
      rstrat[rl[i]] = (rsol[i] > 0) ? rsol[i] : fx_t'(0);
      cstrat[cl[i]] = (csol[i] > 0) ? csol[i] : fx_t'(0);
    end
    for (int j = 0; j < nc; j++) begin
      z = '0;
      for (int i = 0; i < nr; i++) z = add_sat(z, times(rstrat[i], shadow_pay[i][j]));
      if (z < sub_sat(rsol[k], MARGIN)) ok = 1'b0;
    end
    for (int i = 0; i < nr; i++) begin
      z = '0;
      for (int j = 0; j < nc; j++) z = add_sat(z, times(shadow_pay[i][j], cstrat[j]));
      if (z > add_sat(rsol[k], MARGIN)) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic int clamp_dim(logic [2:0] v);
    if (v == 0) return 1;
    if (v > 4) return 4;
    return int'(v);
  endfunction

  task automatic predict_equilibrium(int nr, int nc);
    int cnt;
    outcome_t o;
    for (int k = 1; k <= ((nr < nc) ? nr : nc); k++)
      for (int rm = 0; rm < (1 << nr); rm++) begin
        if ($countones(rm) != k) continue;
        cnt = 0;
        for (int i = 0; i < nr; i++) if (rm[i]) rl[cnt++] = i;
        for (int cm = 0; cm < (1 << nc); cm++) begin
          if ($countones(cm) != k) continue;
          cnt = 0;
          for (int i = 0; i < nc; i++) if (cm[i]) cl[cnt++] = i;
          if (!support_pair_holds(nr, nc, k)) continue;
          o = '{KIND_VALUE, 2'd0, rsol[k], 1'b0};
          queue_outcome(o);
          for (int i = 0; i < nr; i++) queue_outcome('{KIND_ROW, 2'(i), rstrat[i], 1'b0});
          for (int i = 0; i < nc; i++)
            queue_outcome('{KIND_COL, 2'(i), cstrat[i], i == nc - 1});
          return;
        end
      end
    queue_outcome('{KIND_NONE, 2'd0, fx_t'(0), 1'b1});
  endtask

  // Sends one request; the sender pauses for a random gap, possibly none, between bursts of random length.
  task automatic send_request(logic [2:0] nr, logic [2:0] nc, logic [1:0] ri,
                              logic [1:0] ci, fx_t val, logic fin);
    int gap;
    logic was_busy;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 7);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    num_rows <= nr;
    num_cols <= nc;
    row_index <= ri;
    col_index <= ci;
    entry <= val;
    last_entry <= fin;
    do begin
      @(negedge clk);
      was_busy = busy;
      @(posedge clk);
    end while (was_busy);
    item_count++;
    shadow_pay[ri][ci] = val;
    if (fin) predict_equilibrium(clamp_dim(nr), clamp_dim(nc));
  endtask

  function automatic fx_t payoff_sample();
    case ($urandom_range(0, 3))
      0: return fx_t'($signed($urandom_range(0, 4)) - 2) <<< 40;
      1: return {$urandom, $urandom};
      default: return fx_t'($signed($urandom_range(0, 16000)) - 8000) <<< 28;
    endcase
  endfunction

  // Every store entry is written first, so no solve reads an unwritten entry.
  task automatic test_full_load();
    for (int i = 0; i < 16; i++)
      send_request(3'd4, 3'd4, 2'(i / 4), 2'(i % 4), payoff_sample(), i == 15);
  endtask

  task automatic test_extremes();
    send_request(3'd1, 3'd1, 2'd0, 2'd0, I64_MAX, 1'b1);
    send_request(3'd1, 3'd1, 2'd0, 2'd0, I64_MIN, 1'b1);
    send_request(3'd0, 3'd0, 2'd0, 2'd0, '0, 1'b1);
    send_request(3'd7, 3'd1, 2'd3, 2'd0, -(64'sd1 <<< 40), 1'b1);
    send_request(3'd1, 3'd6, 2'd3, 2'd3, 64'sd1 <<< 40, 1'b0);
    send_request(3'd5, 3'd7, 2'd2, 2'd2, 64'sh5555_5555_5555_5555, 1'b1);
    // Matching pennies has only a fully mixed equilibrium.
    send_request(3'd2, 3'd2, 2'd0, 2'd0, 64'sd1 <<< 40, 1'b0);
    send_request(3'd2, 3'd2, 2'd0, 2'd1, -(64'sd1 <<< 40), 1'b0);
    send_request(3'd2, 3'd2, 2'd1, 2'd0, -(64'sd1 <<< 40), 1'b0);
    send_request(3'd2, 3'd2, 2'd1, 2'd1, 64'sd1 <<< 40, 1'b1);
    // Identical rows and columns make the larger systems singular.
    send_request(3'd2, 3'd2, 2'd1, 2'd0, 64'sd1 <<< 40, 1'b0);
    send_request(3'd2, 3'd2, 2'd0, 2'd1, 64'sd1 <<< 40, 1'b1);
    send_request(3'd2, 3'd3, 2'd1, 2'd2, 64'shAAAA_AAAA_AAAA_AAAA, 1'b1);
  endtask

  task automatic test_random_games();
    logic [2:0] nr, nc;
    int er, ec;
    while (item_count < 330) begin
      nr = ($urandom_range(0, 7) == 0) ? 3'd4 : 3'($urandom_range(1, 3));
      nc = ($urandom_range(0, 7) == 0) ? 3'd4 : 3'($urandom_range(1, 3));
      if ($urandom_range(0, 9) == 0) nr = $urandom_range(0, 1) ? 3'd0 : 3'($urandom_range(5, 7));
      if ($urandom_range(0, 9) == 0) nc = $urandom_range(0, 1) ? 3'd0 : 3'($urandom_range(5, 7));
      er = clamp_dim(nr);
      ec = clamp_dim(nc);
      if ($urandom_range(0, 6) == 0) begin
        send_request(nr, nc, 2'($urandom), 2'($urandom), payoff_sample(), 1'b1);
      end else begin
        if ($urandom_range(0, 3) == 0)
          send_request(3'($urandom), 3'($urandom), 2'($urandom), 2'($urandom),
                       payoff_sample(), 1'b0);
        for (int i = 0; i < er * ec; i++)
          send_request(nr, nc, 2'(i / ec), 2'(i % ec), payoff_sample(), i == er * ec - 1);
      end
    end
  endtask

  always @(negedge clk) begin
    outcome_t want;
    if (!rst && result_strobe) begin
      if (outcome_q.size() == 0) begin
        $display("%0t: unexpected result kind %0d pos %0d amount %0d", $time,
                 result_kind, position, amount);
        error_count++;
      end else begin
        want = outcome_q.pop_front();
        if (result_kind !== want.kind) begin
          $display("%0t: result_kind expected %0d actual %0d", $time, want.kind, result_kind);
          error_count++;
        end
        if (position !== want.pos) begin
          $display("%0t: position expected %0d actual %0d", $time, want.pos, position);
          error_count++;
        end
        if (amount !== want.amt) begin
          $display("%0t: amount expected %0d actual %0d", $time, want.amt, amount);
          error_count++;
        end
        if (last_result !== want.last) begin
          $display("%0t: last_result expected %0d actual %0d", $time, want.last, last_result);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_full_load();
    test_extremes();
    test_random_games();
    start <= 1'b0;
    while (outcome_q.size() != 0 || busy) @(posedge clk);
    repeat (50) @(posedge clk);
    if (error_count == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

  initial begin
    #2_000_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule

### files.f
rtl/mgs_pkg.sv
rtl/mgs_ram.sv
rtl/mgs_mul.sv
rtl/mgs_div.sv
rtl/matrix_game_solver.sv
sim/tb.sv
